### hw/rtl/nbc_pkg.sv
// ----------------------------------------------------------------------------
// nbc_pkg: shared constants and types for the naive Bayes classifier
// Sizes of the count table, the limb-serial big-number datapath and the
// command/status bundle between the sequencer and the accumulator unit.
// ----------------------------------------------------------------------------
package nbc_pkg;

	localparam int NUM_FEATURES = 8;
	localparam int COUNT_BITS   = 16;

	localparam int NUM_CELLS = NUM_FEATURES * 4;
	localparam int FEAT_W    = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
	localparam int CELL_W    = FEAT_W + 2;
	localparam int PASS_W    = FEAT_W + 2;

	// one factor is a count plus one or a total plus two
	localparam int FACT_W = COUNT_BITS + 1;

	localparam int LIMB_W     = 32;
	localparam int PROD_BITS  = COUNT_BITS + 2 * NUM_FEATURES * FACT_W;
	localparam int LIMBS      = (PROD_BITS + LIMB_W - 1) / LIMB_W;
	localparam int LIMB_IDX_W = (LIMBS > 1) ? $clog2(LIMBS) : 1;
	localparam int MUL_W      = LIMB_W + FACT_W + 1;

	typedef enum logic [1:0] {
		ACC_NOP,
		ACC_LOAD,
		ACC_MUL,
		ACC_CMP
	} acc_op_t;

	typedef struct packed {
		acc_op_t                 op;
		logic                    side;     // 0 = left product, 1 = right product
		logic [LIMB_IDX_W-1:0]   limb;
		logic                    first;    // first limb of a pass
		logic [FACT_W-1:0]       factor;
		logic [COUNT_BITS-1:0]   load_val;
	} acc_cmd_t;

	typedef struct packed {
		logic ge;    // left product >= right product
		logic ovf;   // carry left over after a pass
	} acc_sts_t;

endpackage

### hw/rtl/nbc_acc.sv
// ----------------------------------------------------------------------------
// nbc_acc: limb-serial big-number multiply and compare unit
// Holds both cross products as 32-bit limbs. One shared multiplier scales
// one limb per cycle by a narrow factor; compare walks limbs from the top.
// ----------------------------------------------------------------------------
module nbc_acc (
	input  logic              clk,
	input  logic              arst_n,
	input  nbc_pkg::acc_cmd_t cmd,
	output nbc_pkg::acc_sts_t sts
);
	import nbc_pkg::*;

	logic [LIMB_W-1:0] lhs_q [LIMBS];
	logic [LIMB_W-1:0] rhs_q [LIMBS];
	logic [FACT_W-1:0] carry_q;
	logic              dec_q;
	logic              lt_q;

	logic [LIMB_W-1:0] lhs_rd;
	logic [LIMB_W-1:0] rhs_rd;
	logic [LIMB_W-1:0] mul_a;
	logic [FACT_W-1:0] carry_in;
	logic [MUL_W-1:0]  prod;

	assign lhs_rd   = lhs_q[cmd.limb];
	assign rhs_rd   = rhs_q[cmd.limb];
	assign mul_a    = cmd.side ? rhs_rd : lhs_rd;
	assign carry_in = cmd.first ? '0 : carry_q;
	assign prod     = MUL_W'(mul_a) * MUL_W'(cmd.factor) + MUL_W'(carry_in);

	always_ff @(posedge clk) begin
		if (cmd.op == ACC_LOAD) begin
			for (int k = 0; k < LIMBS; k++) begin
				if (cmd.side) begin
					rhs_q[k] <= (k == 0) ? LIMB_W'(cmd.load_val) : '0;
				end else begin
					lhs_q[k] <= (k == 0) ? LIMB_W'(cmd.load_val) : '0;
				end
			end
		end else if (cmd.op == ACC_MUL) begin
			if (cmd.side) begin
				rhs_q[cmd.limb] <= prod[LIMB_W-1:0];
			end else begin
				lhs_q[cmd.limb] <= prod[LIMB_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= '0;
			dec_q   <= 1'b0;
			lt_q    <= 1'b0;
		end else begin
			if (cmd.op == ACC_MUL) begin
				carry_q <= prod[LIMB_W +: FACT_W];
			end
			// most significant differing limb decides
			if (cmd.op == ACC_CMP && (cmd.first || !dec_q)) begin
				dec_q <= (lhs_rd != rhs_rd);
				lt_q  <= (lhs_rd < rhs_rd);
			end
		end
	end

	assign sts.ge  = !lt_q;
	assign sts.ovf = (carry_q != '0);

endmodule

### hw/rtl/binary_naive_bayes_classifier_top.sv
// ----------------------------------------------------------------------------
// binary_naive_bayes_classifier_top: Bernoulli naive Bayes, two classes
// Trains per-feature counts and classifies by exact cross-multiplication.
// ----------------------------------------------------------------------------
// A train beat (tuser = 0) does one saturating increment per feature, then
// one for the class total. A classify beat (tuser = 1) builds both cross
// products in 32-bit limbs with a single 32 x 17 multiplier, one limb per
// cycle, four factors per feature, then compares them limb by limb from the
// top. s_tready is high only between beats; a finished prediction waits in
// the output register while the next beat is taken. Ties and an empty model
// predict class 1.
module binary_naive_bayes_classifier_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] feature_bits, [8] label, rest zero
	input  logic        s_tuser,   // [0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // [0] predicted_class, rest zero
);
	import nbc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TRAIN,
		ST_TOTAL,
		ST_LOAD_L,
		ST_LOAD_R,
		ST_MUL,
		ST_CMP,
		ST_DONE
	} state_t;

	localparam logic [FEAT_W-1:0]     FEAT_LAST = FEAT_W'(NUM_FEATURES - 1);
	localparam logic [LIMB_IDX_W-1:0] LIMB_LAST = LIMB_IDX_W'(LIMBS - 1);

	state_t                 state_q;
	logic [PASS_W-1:0]      pass_q;
	logic [LIMB_IDX_W-1:0]  limb_q;
	logic [NUM_FEATURES-1:0] fv_q;
	logic                   label_q;
	logic                   m_tvalid_q;
	logic                   pred_q;

	logic [COUNT_BITS-1:0]  counts_q [NUM_CELLS];
	logic [COUNT_BITS-1:0]  pos_total_q;
	logic [COUNT_BITS-1:0]  neg_total_q;

	logic [NUM_FEATURES-1:0] fv_in;
	logic [FEAT_W-1:0]      feat;
	logic                   fval;
	logic [CELL_W-1:0]      train_idx;
	logic [COUNT_BITS-1:0]  cp;
	logic [COUNT_BITS-1:0]  cn;
	logic [COUNT_BITS-1:0]  inc_in;
	logic [COUNT_BITS-1:0]  inc_out;
	logic                   s_acc;

	acc_cmd_t acc_cmd;
	acc_sts_t acc_sts;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'b0, pred_q};

	// features past the 8 input bits read as zero
	always_comb begin
		for (int i = 0; i < NUM_FEATURES; i++) begin
			fv_in[i] = (i < 8) ? s_tdata[i % 8] : 1'b0;
		end
	end

	assign feat      = pass_q[PASS_W-1:2];
	assign fval      = fv_q[feat];
	assign train_idx = {feat, fval, label_q};
	assign cp        = counts_q[{feat, fval, 1'b1}];
	assign cn        = counts_q[{feat, fval, 1'b0}];

	// shared saturating incrementer
	assign inc_in  = (state_q == ST_TRAIN) ? counts_q[train_idx]
	                 : (label_q ? pos_total_q : neg_total_q);
	assign inc_out = (inc_in == '1) ? inc_in : inc_in + COUNT_BITS'(1);

	always_comb begin
		acc_cmd          = '0;
		acc_cmd.op       = ACC_NOP;
		acc_cmd.limb     = limb_q;
		acc_cmd.side     = pass_q[1];
		acc_cmd.first    = (limb_q == '0);
		case (pass_q[1:0])
			2'd0:    acc_cmd.factor = FACT_W'(cp) + FACT_W'(1);
			2'd1:    acc_cmd.factor = FACT_W'(neg_total_q) + FACT_W'(2);
			2'd2:    acc_cmd.factor = FACT_W'(cn) + FACT_W'(1);
			default: acc_cmd.factor = FACT_W'(pos_total_q) + FACT_W'(2);
		endcase
		unique case (state_q)
			ST_LOAD_L: begin
				acc_cmd.op       = ACC_LOAD;
				acc_cmd.side     = 1'b0;
				acc_cmd.load_val = pos_total_q;
			end
			ST_LOAD_R: begin
				acc_cmd.op       = ACC_LOAD;
				acc_cmd.side     = 1'b1;
				acc_cmd.load_val = neg_total_q;
			end
			ST_MUL: acc_cmd.op = ACC_MUL;
			ST_CMP: begin
				acc_cmd.op    = ACC_CMP;
				acc_cmd.first = (limb_q == LIMB_LAST);
			end
			default: acc_cmd.op = ACC_NOP;
		endcase
	end

	nbc_acc u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (acc_cmd),
		.sts    (acc_sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CELLS; c++) begin
				counts_q[c] <= '0;
			end
			pos_total_q <= '0;
			neg_total_q <= '0;
		end else if (state_q == ST_TRAIN) begin
			counts_q[train_idx] <= inc_out;
		end else if (state_q == ST_TOTAL) begin
			if (label_q) begin
				pos_total_q <= inc_out;
			end else begin
				neg_total_q <= inc_out;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			fv_q    <= fv_in;
			label_q <= s_tdata[8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pass_q     <= '0;
			limb_q     <= '0;
			m_tvalid_q <= 1'b0;
			pred_q     <= 1'b0;
		end else begin
			// a new result loaded in ST_DONE replaces the one leaving
			if (m_tvalid_q && m_tready && state_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					pass_q <= '0;
					limb_q <= '0;
					if (s_acc) begin
						state_q <= s_tuser ? ST_LOAD_L : ST_TRAIN;
					end
				end
				ST_TRAIN: begin
					pass_q <= pass_q + PASS_W'(4);
					if (feat == FEAT_LAST) begin
						state_q <= ST_TOTAL;
					end
				end
				ST_TOTAL:  state_q <= ST_IDLE;
				ST_LOAD_L: state_q <= ST_LOAD_R;
				ST_LOAD_R: state_q <= ST_MUL;
				ST_MUL: begin
					if (limb_q == LIMB_LAST) begin
						pass_q <= pass_q + PASS_W'(1);
						// compare starts from the top limb
						if (feat == FEAT_LAST && pass_q[1:0] == 2'd3) begin
							state_q <= ST_CMP;
						end else begin
							limb_q <= '0;
						end
					end else begin
						limb_q <= limb_q + LIMB_IDX_W'(1);
					end
				end
				ST_CMP: begin
					limb_q <= limb_q - LIMB_IDX_W'(1);
					if (limb_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						pred_q     <= acc_sts.ge;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// product never outgrows the limb array
	a_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL && limb_q == LIMB_LAST) |=> !acc_sts.ovf)
		else $error("cross product overflowed the limb array");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == ST_DONE)
		else $error("result beat not produced by a classify");

	a_train_path: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && !s_tuser) |=> state_q == ST_TRAIN)
		else $error("train beat did not start training");

	a_totals_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_total_q >= $past(pos_total_q)) && (neg_total_q >= $past(neg_total_q)))
		else $error("class total decreased");

endmodule
